>>> sv/rled_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the decimal run-length encoder.
// No dependencies; the files that use it refer to this package by scoped names.
package rled_pkg;

    localparam int COUNT_WIDTH = 16;
    // Run counter width: capped at 16 so a count never exceeds five digits.
    localparam int COUNT_BITS  = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_BITS-1:0] RUN_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] RUN_ONE = COUNT_BITS'(1);

    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int DIG_IDX_W  = $clog2(BCD_DIGITS);
    localparam int STEP_W     = $clog2(COUNT_BITS + 1);

    // Command queue between front and back; depth is a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] TERM_BYTE  = 8'h00;

    // One unit of back-end work: a finished run and/or a terminator.
    typedef struct packed {
        logic                  emit_run;
        logic                  term;
        logic [7:0]            run_byte;
        logic [COUNT_BITS-1:0] run_len;
    } t_cmd;

endpackage

>>> sv/rled_front.sv
`timescale 1ns / 1ps
// Front end: holds the open run and pushes a queue command when a run closes or a terminator arrives.
// Depends on rled_pkg.
module rled_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [7:0]    i_byte_in,
    input  logic          i_q_full,
    output logic          o_push,
    output rled_pkg::t_cmd o_cmd
);

    logic                            r_have;
    logic [7:0]                      r_byte;
    logic [rled_pkg::COUNT_BITS-1:0] r_len;
    logic                            n_have;
    logic [7:0]                      n_byte;
    logic [rled_pkg::COUNT_BITS-1:0] n_len;
    logic                            accept;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        n_have          = r_have;
        n_byte          = r_byte;
        n_len           = r_len;
        o_push          = 1'b0;
        o_cmd.emit_run  = r_have;
        o_cmd.term      = 1'b0;
        o_cmd.run_byte  = r_byte;
        o_cmd.run_len   = r_len;
        if (accept) begin
            if (i_byte_in == rled_pkg::TERM_BYTE) begin
                o_push     = 1'b1;
                o_cmd.term = 1'b1;
                n_have     = 1'b0;
                n_byte     = rled_pkg::TERM_BYTE;
                n_len      = '0;
            end else if (!r_have) begin
                n_have = 1'b1;
                n_byte = i_byte_in;
                n_len  = rled_pkg::RUN_ONE;
            end else if (i_byte_in == r_byte) begin
                if (r_len == rled_pkg::RUN_MAX) begin
                    o_push = 1'b1;
                    n_len  = rled_pkg::RUN_ONE;
                end else begin
                    n_len = r_len + rled_pkg::RUN_ONE;
                end
            end else begin
                o_push = 1'b1;
                n_byte = i_byte_in;
                n_len  = rled_pkg::RUN_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_byte <= '0;
            r_len  <= '0;
        end else begin
            r_have <= n_have;
            r_byte <= n_byte;
            r_len  <= n_len;
        end
    end

endmodule

>>> sv/rled_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front and back ends.
// Depends on rled_pkg.
module rled_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rled_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output rled_pkg::t_cmd o_cmd,
    output logic           o_full,
    output logic           o_nonempty
);

    rled_pkg::t_cmd                r_mem [rled_pkg::QUEUE_DEPTH];
    logic [rled_pkg::QPTR_W-1:0]   r_wr;
    logic [rled_pkg::QPTR_W-1:0]   r_rd;
    logic [rled_pkg::QCNT_W-1:0]   r_cnt;
    logic                          do_pop;

    assign o_full     = (r_cnt == rled_pkg::QCNT_W'(rled_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_cmd      = r_mem[r_rd];
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> sv/rled_back.sv
`timescale 1ns / 1ps
// Back end: converts run lengths to decimal (shift-add-3) and emits result beats.
// Depends on rled_pkg.
module rled_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rled_pkg::t_cmd i_cmd,
    input  logic           i_q_nonempty,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_out_byte,
    output logic           o_last_of_item
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_DIGIT = 3'd2;
    localparam logic [2:0] ST_BYTE  = 3'd3;
    localparam logic [2:0] ST_TERM  = 3'd4;

    logic [2:0]                          r_state, n_state;
    rled_pkg::t_cmd                      r_cmd, n_cmd;
    logic [rled_pkg::BCD_W-1:0]          r_bcd, n_bcd;
    logic [rled_pkg::COUNT_BITS-1:0]     r_bin, n_bin;
    logic [rled_pkg::STEP_W-1:0]         r_step, n_step;
    logic [rled_pkg::DIG_IDX_W-1:0]      r_idx, n_idx;
    logic                                r_started, n_started;
    logic                                r_ov, n_ov;
    logic [7:0]                          r_obyte, n_obyte;
    logic                                r_olast, n_olast;
    logic                                load_ok;
    logic [rled_pkg::BCD_W-1:0]          bcd_adj;
    logic [3:0]                          nib;

    assign load_ok        = !r_ov || !i_out_stall;
    assign o_out_valid    = r_ov;
    assign o_out_byte     = r_obyte;
    assign o_last_of_item = r_olast;
    assign nib            = r_bcd[r_idx*4 +: 4];

    // Add 3 to every BCD digit of five or more before the shift.
    always_comb begin
        for (int d = 0; d < rled_pkg::BCD_DIGITS; d++) begin
            bcd_adj[d*4 +: 4] = (r_bcd[d*4 +: 4] >= 4'd5) ?
                                (r_bcd[d*4 +: 4] + 4'd3) : r_bcd[d*4 +: 4];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_bcd     = r_bcd;
        n_bin     = r_bin;
        n_step    = r_step;
        n_idx     = r_idx;
        n_started = r_started;
        n_ov      = r_ov && i_out_stall;
        n_obyte   = r_obyte;
        n_olast   = r_olast;
        o_pop     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_nonempty) begin
                    o_pop     = 1'b1;
                    n_cmd     = i_cmd;
                    n_bcd     = '0;
                    n_bin     = i_cmd.run_len;
                    n_step    = rled_pkg::STEP_W'(rled_pkg::COUNT_BITS);
                    n_idx     = rled_pkg::DIG_IDX_W'(rled_pkg::BCD_DIGITS - 1);
                    n_started = 1'b0;
                    if (!i_cmd.emit_run) begin
                        n_state = ST_TERM;
                    end else if (i_cmd.run_len > rled_pkg::RUN_ONE) begin
                        n_state = ST_CONV;
                    end else begin
                        n_state = ST_BYTE;
                    end
                end
            end
            ST_CONV: begin
                n_bcd  = {bcd_adj[rled_pkg::BCD_W-2:0], r_bin[rled_pkg::COUNT_BITS-1]};
                n_bin  = {r_bin[rled_pkg::COUNT_BITS-2:0], 1'b0};
                n_step = r_step - 1'b1;
                if (r_step == rled_pkg::STEP_W'(1)) begin
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (nib == 4'd0 && !r_started) begin
                    n_idx = r_idx - 1'b1;
                end else if (load_ok) begin
                    n_ov      = 1'b1;
                    n_obyte   = rled_pkg::ASCII_ZERO + {4'd0, nib};
                    n_olast   = 1'b0;
                    n_started = 1'b1;
                    if (r_idx == '0) begin
                        n_state = ST_BYTE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            ST_BYTE: begin
                if (load_ok) begin
                    n_ov    = 1'b1;
                    n_obyte = r_cmd.run_byte;
                    n_olast = !r_cmd.term;
                    n_state = r_cmd.term ? ST_TERM : ST_IDLE;
                end
            end
            ST_TERM: begin
                if (load_ok) begin
                    n_ov    = 1'b1;
                    n_obyte = rled_pkg::TERM_BYTE;
                    n_olast = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_cmd     <= n_cmd;
        r_bcd     <= n_bcd;
        r_bin     <= n_bin;
        r_step    <= n_step;
        r_idx     <= n_idx;
        r_started <= n_started;
        r_obyte   <= n_obyte;
        r_olast   <= n_olast;
    end

endmodule

>>> sv/run_length_encoder_decimal_top.sv
`timescale 1ns / 1ps
// Path: a beat that closes a run of two or more passes the queue, the pop, COUNT_BITS
//   shift-add-3 steps and the skipping of leading zero digits before its first result is
//   taken; a bare byte or lone terminator skips the conversion.
// Throughput: input takes one beat per cycle while the two-entry command queue has room;
//   the back end finishes one command (digits, byte, terminator) before it pops the next.
// Reset: synchronous, active low; clears the open run, the queue, the back-end state and output valid.
module run_length_encoder_decimal_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_byte_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_item
);

    // Commands from front to queue and from queue to back.
    rled_pkg::t_cmd front_cmd;
    rled_pkg::t_cmd q_cmd;
    logic           front_push;
    logic           q_full;
    logic           q_nonempty;
    logic           back_pop;

    // Front: track the open run, push a command when a run closes or the string ends.
    rled_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_byte_in  (i_byte_in),
        .i_q_full   (q_full),
        .o_push     (front_push),
        .o_cmd      (front_cmd)
    );

    // Queue: decouple input beats from the longer output bursts.
    rled_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (front_push),
        .i_cmd      (front_cmd),
        .i_pop      (back_pop),
        .o_cmd      (q_cmd),
        .o_full     (q_full),
        .o_nonempty (q_nonempty)
    );

    // Back: convert the count to decimal, emit digits, byte and terminator.
    rled_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (q_cmd),
        .i_q_nonempty   (q_nonempty),
        .o_pop          (back_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_item (o_last_of_item)
    );

endmodule

>>> sv/rled_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the decimal run-length encoder, bound to the top level.
// Depends on run_length_encoder_decimal_top.
module rled_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_byte_in,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_last_of_item
);

    // Hold a stalled input beat.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_byte_in))
        else $error("stalled input beat changed");

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_last_of_item))
        else $error("stalled result beat changed");

    // Drop output valid after reset.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A zero byte is only ever the terminator, which always ends its item.
    a_zero_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_byte == 8'h00) |-> o_last_of_item)
        else $error("zero byte not flagged last");

    // A non-final beat carries a digit or a run byte, never zero.
    a_notlast_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_item |-> (o_out_byte != 8'h00))
        else $error("zero byte inside an item");

endmodule

bind run_length_encoder_decimal_top rled_checker u_rled_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_byte_in      (i_byte_in),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_out_byte     (o_out_byte),
    .o_last_of_item (o_last_of_item)
);

>>> tb/run_length_encoder_decimal_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for run_length_encoder_decimal_top: directed and random strings of byte runs in,
// decimal-count encoding out, checked beat by beat. Depends on rled_pkg and the top level.

typedef struct packed {
    logic [7:0] code;
    logic       last;
} t_enc_beat;

// Tracks the open run exactly as the encoder should and queues the encoded beats.
class rle_scoreboard;
    logic [7:0]                      run_byte;
    logic [rled_pkg::COUNT_BITS-1:0] run_len;
    bit                              run_open;
    t_enc_beat                       burst[$];
    t_enc_beat                       encoded_q[$];
    int                              errors;
    int                              beats_in;
    int                              beats_out;
    int                              strings_done;
    int                              longest_run;

    function new();
        run_byte     = '0;
        run_len      = '0;
        run_open     = 1'b0;
        errors       = 0;
        beats_in     = 0;
        beats_out    = 0;
        strings_done = 0;
        longest_run  = 0;
    endfunction

    // Emit the open run: count digits (only when longer than one), then the byte.
    function void close_run();
        int digs[$];
        int v;
        v = int'(run_len);
        if (v > longest_run) longest_run = v;
        if (v > 1) begin
            while (v != 0) begin
                digs.push_front(v % 10);
                v = v / 10;
            end
            foreach (digs[i])
                burst.push_back('{code: rled_pkg::ASCII_ZERO + 8'(digs[i]), last: 1'b0});
        end
        burst.push_back('{code: run_byte, last: 1'b0});
    endfunction

    function void note_byte(logic [7:0] b);
        t_enc_beat tail;
        burst.delete();
        beats_in++;
        if (b == rled_pkg::TERM_BYTE) begin
            if (run_open) close_run();
            burst.push_back('{code: rled_pkg::TERM_BYTE, last: 1'b0});
            run_byte     = '0;
            run_len      = '0;
            run_open     = 1'b0;
            strings_done++;
        end else if (!run_open) begin
            run_byte = b;
            run_len  = rled_pkg::RUN_ONE;
            run_open = 1'b1;
        end else if (b == run_byte) begin
            if (run_len >= rled_pkg::RUN_MAX) begin
                close_run();
                run_len = rled_pkg::RUN_ONE;
            end else begin
                run_len = run_len + 1'b1;
            end
        end else begin
            close_run();
            run_byte = b;
            run_len  = rled_pkg::RUN_ONE;
        end
        if (burst.size() > 0) begin
            tail      = burst.pop_back();
            tail.last = 1'b1;
            burst.push_back(tail);
        end
        foreach (burst[i]) encoded_q.push_back(burst[i]);
    endfunction

    function void check_beat(logic [7:0] code, logic last);
        t_enc_beat want;
        beats_out++;
        if (encoded_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat: expected none, actual byte %h last %b",
                     $time, code, last);
            return;
        end
        want = encoded_q.pop_front();
        if (code !== want.code) begin
            errors++;
            $display("%0t: out_byte mismatch: expected %h, actual %h", $time, want.code, code);
        end
        if (last !== want.last) begin
            errors++;
            $display("%0t: last_of_item mismatch: expected %b, actual %b",
                     $time, want.last, last);
        end
    endfunction
endclass

module run_length_encoder_decimal_top_tb;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 1_000_000;
    // Tail wait after the last expected beat: longest conversion path plus margin.
    localparam int TAIL_CYCLES = 3 + rled_pkg::COUNT_BITS + 20;
    localparam int RANDOM_ITEMS_PER_PHASE = 110;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic [7:0] i_byte_in      = 8'h00;
    logic       i_out_stall    = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_last_of_item;

    rle_scoreboard sb;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_left     = 0;
    int            cycle_count   = 0;

    run_length_encoder_decimal_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_byte_in      (i_byte_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_item (o_last_of_item)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Watchdog: abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, sb.encoded_q.size());
            $display("run_length_encoder_decimal_top_tb: FAIL");
            $finish;
        end
    end

    // Receiver back-pressure: a requested hold-off wins, otherwise stall at random.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Check every output beat that the receiver takes.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_beat(o_out_byte, o_last_of_item);
    end

    // Offer one byte, optionally after a short idle gap; note it once taken.
    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap        = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_in  <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_byte(b);
        @(negedge i_clk);
    endtask

    task automatic send_run(input logic [7:0] b, input int len);
        repeat (len) send_byte(b);
    endtask

    // Drop valid and hold the sender until every expected beat has come out.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (sb.encoded_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte(logic [7:0] prev);
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == prev);
        return b;
    endfunction

    // Well-formed string: runs of distinct neighbors, mostly short, closed by the terminator.
    task automatic send_string();
        int         nruns;
        int         len;
        int         r;
        logic [7:0] b;
        b     = 8'h00;
        nruns = $urandom_range(1, 6);
        repeat (nruns) begin
            b = pick_byte(b);
            r = $urandom_range(99);
            if (r < 65)      len = $urandom_range(1, 3);
            else if (r < 93) len = $urandom_range(4, 12);
            else if (r < 98) len = $urandom_range(13, 40);
            else             len = $urandom_range(95, 105);
            send_run(b, len);
        end
        send_byte(rled_pkg::TERM_BYTE);
    endtask

    // Noise: tiny alphabet so equal neighbors occur by chance, stray terminators,
    // and no guaranteed terminator at the end.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 10);
        repeat (n) begin
            if ($urandom_range(99) < 20)
                send_byte(rled_pkg::TERM_BYTE);
            else if ($urandom_range(1))
                send_byte(8'($urandom_range(1, 3)));
            else
                send_byte(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic random_phase(input int send_pct, input int recv_pct, input bit with_hold);
        int         start_items;
        logic [7:0] b;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_items   = sb.beats_in;
        if (with_hold) begin
            // Hold the receiver off for a long stretch while single-byte runs pile up,
            // so the command queue fills and the input stalls.
            hold_left = 400;
            b         = 8'h00;
            repeat (24) begin
                b = pick_byte(b);
                send_byte(b);
            end
            send_byte(rled_pkg::TERM_BYTE);
        end
        while (sb.beats_in - start_items < RANDOM_ITEMS_PER_PHASE) begin
            if ($urandom_range(99) < 15) send_noise();
            else                         send_string();
        end
        wait_drain();
    endtask

    initial begin
        sb = new();

        // Hold reset, then release it at a falling edge.
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: lone terminator, single byte, extremes, counts of two and three,
        // digit-like bytes, back-to-back terminators.
        send_idle_pct = 15;
        recv_idle_pct = 53;
        send_byte(rled_pkg::TERM_BYTE);
        send_byte(8'h01);
        send_byte(rled_pkg::TERM_BYTE);
        send_run(8'hFF, 2);
        send_run(8'h7F, 3);
        send_byte(8'h55);
        send_byte(rled_pkg::TERM_BYTE);
        send_run(8'hAA, 2);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(rled_pkg::TERM_BYTE);
        send_run(8'h31, 2);
        send_byte(8'h80);
        send_byte(rled_pkg::TERM_BYTE);
        send_byte(rled_pkg::TERM_BYTE);
        wait_drain();

        // Random traffic in three idle profiles.
        random_phase(15, 53, 1'b1);
        random_phase(53, 15, 1'b0);
        random_phase(0, 0, 1'b0);

        // Let any stray beat surface before closing.
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d input beats and %0d output beats over %0d strings;",
                 sb.beats_in, sb.beats_out, sb.strings_done);
        $display("longest run %0d, with a long receiver hold-off and drained pauses",
                 sb.longest_run);
        if (sb.errors == 0 && sb.encoded_q.size() == 0) begin
            $display("run_length_encoder_decimal_top_tb: PASS");
        end else begin
            $display("%0d mismatches, %0d beats never arrived", sb.errors, sb.encoded_q.size());
            $display("run_length_encoder_decimal_top_tb: FAIL");
        end
        $finish;
    end

endmodule
